// ===== sv/sorted_list_insert_delete_assert.svh =====
// assertion macros for the sorted list block
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTHESIS

`define SLI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted list assertion failed");

`define SLI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted list assertion failed");

`else

`define SLI_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SLI_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/sli_pkg.sv =====
// types and constants shared by the sorted list cells and top level
package sli_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic               last;
      logic [4:0]         fill_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] key;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_DUMP = 2'b10
   } state_type;

endpackage

// ===== sv/sorted_list_insert_delete.sv =====
// top level of the sorted list: cell chain, command decode and dump sequencer
//
// channel   direction  handshake             payload
// request   in         start / busy          req_data  (opcode, value)
// response  out        rsp_strobe (1 cycle)  rsp_data  (status, read_value, last, fill_count)
//
// insert and delete: all cells compare against the key in parallel and shift together;
// the response is registered and comes in the cycle after start, and a new word may come
// at once. a dump of n entries rotates the chain through cell 0, one response a cycle,
// busy until the last entry is read out. an empty dump answers with status empty. reset
// is synchronous and clears the fill count and sequencer; response cannot stall.
`include "sorted_list_insert_delete_assert.svh"

module sorted_list_insert_delete #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sli_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sli_pkg::rsp_type rsp_data
);

   localparam int COUNT_W = $clog2(CAPACITY + 1);

   sli_pkg::state_type   state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   remain_ff, remain_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   sli_pkg::rsp_type     rsp_ff, rsp_in;

   sli_pkg::cell_ctl_type ctl;
   logic signed [31:0]    cell_value [CAPACITY];
   logic [CAPACITY-1:0]   cell_lt;
   logic [CAPACITY-1:0]   cell_hit;
   logic                  found;
   logic                  accept;
   logic [COUNT_W+4:0]    fill_wide;

   assign found  = |cell_hit;
   assign accept = start && (state_ff == sli_pkg::FSM_IDLE);
   assign busy   = (state_ff != sli_pkg::FSM_IDLE);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_v;
      logic               left_l;
      logic signed [31:0] right_v;

      if (i == 0) begin : g_head
         assign left_v = req_data.value;
         assign left_l = 1'b1;
      end else begin : g_mid
         assign left_v = cell_value[i-1];
         assign left_l = cell_lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_v = cell_value[i];
      end else begin : g_inner
         assign right_v = cell_value[i+1];
      end

      sli_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .found       (found),
         .occupied    (COUNT_W'(i) < count_ff),
         .is_tail     (count_ff == COUNT_W'(i + 1)),
         .left_value  (left_v),
         .left_lt     (left_l),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .value       (cell_value[i]),
         .lt          (cell_lt[i]),
         .hit         (cell_hit[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      ctl.op        = sli_pkg::CELL_HOLD;
      ctl.key       = req_data.value;

      unique case (state_ff)
         sli_pkg::FSM_IDLE: begin
            if (accept) begin
               unique case (req_data.opcode)
                  sli_pkg::OP_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.last   = 1'b1;
                     if (count_ff == COUNT_W'(CAPACITY)) begin
                        rsp_in.status = sli_pkg::ST_FULL;
                     end else begin
                        ctl.op        = sli_pkg::CELL_INSERT;
                        count_in      = count_ff + COUNT_W'(1);
                        rsp_in.status = sli_pkg::ST_OK;
                     end
                  end
                  sli_pkg::OP_DELETE: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.last   = 1'b1;
                     ctl.op        = sli_pkg::CELL_DELETE;
                     if (found) begin
                        count_in      = count_ff - COUNT_W'(1);
                        rsp_in.status = sli_pkg::ST_OK;
                     end else begin
                        rsp_in.status = sli_pkg::ST_NOTFOUND;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.last   = 1'b1;
                        rsp_in.status = sli_pkg::ST_EMPTY;
                     end else begin
                        remain_in = count_ff;
                        state_in  = sli_pkg::FSM_DUMP;
                     end
                  end
               endcase
            end
         end
         sli_pkg::FSM_DUMP: begin
            ctl.op            = sli_pkg::CELL_ROTATE;
            rsp_strobe_in     = 1'b1;
            rsp_in.status     = sli_pkg::ST_OK;
            rsp_in.read_value = cell_value[0];
            rsp_in.last       = (remain_ff == COUNT_W'(1));
            remain_in         = remain_ff - COUNT_W'(1);
            if (remain_ff == COUNT_W'(1)) begin
               state_in = sli_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = sli_pkg::FSM_IDLE;
         end
      endcase

      fill_wide         = {5'b0, count_in};
      rsp_in.fill_count = fill_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sli_pkg::FSM_IDLE;
         count_ff      <= '0;
         remain_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         remain_ff     <= remain_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `SLI_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_W'(CAPACITY))
   `SLI_ASSERT_NEXT(a_dump_emits, clock, reset, state_ff == sli_pkg::FSM_DUMP, rsp_strobe)
   `SLI_ASSERT_NEXT(a_full_drop, clock, reset,
      accept && req_data.opcode == sli_pkg::OP_INSERT && count_ff == COUNT_W'(CAPACITY),
      rsp_data.status == sli_pkg::ST_FULL && $stable(count_ff))
   `SLI_ASSERT_NOW(a_last_idle, clock, reset, rsp_strobe && rsp_data.last, !busy)

endmodule

// ===== sv/sli_cell.sv =====
// one storage cell of the sorted chain
module sli_cell (
   input  logic                 clock,
   input  sli_pkg::cell_ctl_type ctl,
   input  logic                 found,
   input  logic                 occupied,
   input  logic                 is_tail,
   input  logic signed [31:0]   left_value,
   input  logic                 left_lt,
   input  logic signed [31:0]   right_value,
   input  logic signed [31:0]   head_value,
   output logic signed [31:0]   value,
   output logic                 lt,
   output logic                 hit
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               eq;

   assign lt    = occupied && (value_ff < ctl.key);
   assign eq    = occupied && (value_ff == ctl.key);
   // first cell not below the key and equal to it
   assign hit   = eq && left_lt;
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         sli_pkg::CELL_INSERT: begin
            if (!lt) begin
               value_in = left_lt ? ctl.key : left_value;
            end
         end
         sli_pkg::CELL_DELETE: begin
            if (found && !lt) begin
               value_in = right_value;
            end
         end
         sli_pkg::CELL_ROTATE: begin
            value_in = is_tail ? head_value : right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the sorted list block: directed words, then random words
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_WORDS = 435;
   localparam int REPORT_LIMIT = 10;

   localparam logic [1:0] OP_DUMP     = 2'd2;
   localparam logic [1:0] OP_DUMP_ALT = 2'd3;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic [1:0]         opcode;
      logic signed [31:0] value;
      bit                 typed;
      logic [1:0]         status;
      logic [4:0]         fill;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   sli_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   sli_pkg::rsp_type rsp_data;

   logic signed [31:0] sorted_model [$];
   sli_pkg::rsp_type   expected_rsps [$];

   int idle_pct = 0;
   int cycle_count = 0;
   int error_count = 0;
   int rsp_count = 0;
   int words_sent = 0;
   int dump_count = 0;
   int full_count = 0;
   int miss_count = 0;
   int empty_count = 0;

   directed_row_type directed_rows [26] = '{
      '{OP_DUMP,            32'sd0,         1'b1, sli_pkg::ST_EMPTY,    5'd0},
      '{sli_pkg::OP_DELETE, 32'sd5,         1'b1, sli_pkg::ST_NOTFOUND, 5'd0},
      '{sli_pkg::OP_INSERT, VAL_MAX,        1'b1, sli_pkg::ST_OK,       5'd1},
      '{sli_pkg::OP_INSERT, VAL_MIN,        1'b1, sli_pkg::ST_OK,       5'd2},
      '{sli_pkg::OP_INSERT, 32'sd0,         1'b1, sli_pkg::ST_OK,       5'd3},
      '{sli_pkg::OP_INSERT, -32'sd1,        1'b1, sli_pkg::ST_OK,       5'd4},
      '{sli_pkg::OP_INSERT, 32'sd0,         1'b1, sli_pkg::ST_OK,       5'd5},
      '{OP_DUMP,            -32'sd1,        1'b0, sli_pkg::ST_OK,       5'd0},
      '{sli_pkg::OP_DELETE, 32'sd0,         1'b1, sli_pkg::ST_OK,       5'd4},
      '{sli_pkg::OP_DELETE, 32'sd12345,     1'b1, sli_pkg::ST_NOTFOUND, 5'd4},
      '{OP_DUMP_ALT,        32'sd77,        1'b0, sli_pkg::ST_OK,       5'd0},
      '{sli_pkg::OP_INSERT, 32'sh5555_5555, 1'b1, sli_pkg::ST_OK,       5'd5},
      '{sli_pkg::OP_INSERT, 32'shaaaa_aaaa, 1'b1, sli_pkg::ST_OK,       5'd6},
      '{sli_pkg::OP_INSERT, 32'sd7,         1'b1, sli_pkg::ST_OK,       5'd7},
      '{sli_pkg::OP_INSERT, 32'sd7,         1'b1, sli_pkg::ST_OK,       5'd8},
      '{sli_pkg::OP_INSERT, 32'sd1,         1'b1, sli_pkg::ST_OK,       5'd9},
      '{sli_pkg::OP_INSERT, -32'sd2,        1'b1, sli_pkg::ST_OK,       5'd10},
      '{sli_pkg::OP_INSERT, 32'sd100,       1'b1, sli_pkg::ST_OK,       5'd11},
      '{sli_pkg::OP_INSERT, -32'sd100,      1'b1, sli_pkg::ST_OK,       5'd12},
      '{sli_pkg::OP_INSERT, 32'sh4000_0000, 1'b1, sli_pkg::ST_OK,       5'd13},
      '{sli_pkg::OP_INSERT, 32'shc000_0000, 1'b1, sli_pkg::ST_OK,       5'd14},
      '{sli_pkg::OP_INSERT, 32'sd2,         1'b1, sli_pkg::ST_OK,       5'd15},
      '{sli_pkg::OP_INSERT, 32'sd3,         1'b1, sli_pkg::ST_OK,       5'd16},
      '{sli_pkg::OP_INSERT, 32'sd9,         1'b1, sli_pkg::ST_FULL,     5'd16},
      '{OP_DUMP,            32'sd0,         1'b0, sli_pkg::ST_OK,       5'd0},
      '{sli_pkg::OP_DELETE, VAL_MIN,        1'b1, sli_pkg::ST_OK,       5'd15}
   };

   sorted_list_insert_delete #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still awaited",
                  cycle_count, expected_rsps.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic void report_error(string what, sli_pkg::rsp_type want,
                                        sli_pkg::rsp_type got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%s at cycle %0d: expected st=%0d val=%0d last=%0b fill=%0d,", what,
                  cycle_count, want.status, want.read_value, want.last, want.fill_count);
         $display("   got st=%0d val=%0d last=%0b fill=%0d",
                  got.status, got.read_value, got.last, got.fill_count);
      end
   endfunction

   // sorted table behaviour: updates the model and returns the words a command causes
   function automatic void predict_command(input sli_pkg::req_type w,
                                           ref sli_pkg::rsp_type res[$]);
      int               pos;
      int               n;
      sli_pkg::rsp_type r;
      res.delete();
      n = sorted_model.size();
      r = '0;
      r.last = 1'b1;
      if (w.opcode[1]) begin
         dump_count++;
         if (n == 0) begin
            empty_count++;
            r.status = sli_pkg::ST_EMPTY;
            res.push_back(r);
         end else begin
            foreach (sorted_model[i]) begin
               r.status     = sli_pkg::ST_OK;
               r.read_value = sorted_model[i];
               r.last       = (i == n - 1);
               r.fill_count = 5'(n);
               res.push_back(r);
            end
         end
      end else if (w.opcode == sli_pkg::OP_INSERT) begin
         if (n >= CAPACITY) begin
            full_count++;
            r.status = sli_pkg::ST_FULL;
         end else begin
            pos = 0;
            while (pos < n && sorted_model[pos] < w.value) pos++;
            sorted_model.insert(pos, w.value);
            r.status = sli_pkg::ST_OK;
         end
         r.fill_count = 5'(sorted_model.size());
         res.push_back(r);
      end else begin
         pos = -1;
         for (int i = 0; i < n; i++) begin
            if (sorted_model[i] == w.value) begin
               pos = i;
               break;
            end
         end
         if (pos < 0) begin
            miss_count++;
            r.status = sli_pkg::ST_NOTFOUND;
         end else begin
            sorted_model.delete(pos);
            r.status = sli_pkg::ST_OK;
         end
         r.fill_count = 5'(sorted_model.size());
         res.push_back(r);
      end
   endfunction

   task automatic send_word(input sli_pkg::req_type w, input bit typed,
                            input sli_pkg::rsp_type typed_rsp);
      sli_pkg::rsp_type predicted [$];
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      words_sent++;
      predict_command(w, predicted);
      if (typed) expected_rsps.push_back(typed_rsp);
      else foreach (predicted[i]) expected_rsps.push_back(predicted[i]);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed(32'($urandom_range(0, 20))) - 32'sd10;
         4: begin
            case ($urandom_range(0, 3))
               0: return VAL_MIN;
               1: return VAL_MAX;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      sli_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            report_error("unexpected word", '0, rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status || rsp_data.read_value !== want.read_value ||
                rsp_data.last !== want.last || rsp_data.fill_count !== want.fill_count)
               report_error("mismatch", want, rsp_data);
         end
      end
   end

   initial begin
      sli_pkg::req_type w;
      sli_pkg::rsp_type typed_rsp;
      bit               fill_mode;
      int               roll;
      int               n;
      fill_mode = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         w.opcode             = directed_rows[i].opcode;
         w.value              = directed_rows[i].value;
         typed_rsp            = '0;
         typed_rsp.status     = directed_rows[i].status;
         typed_rsp.last       = 1'b1;
         typed_rsp.fill_count = directed_rows[i].fill;
         send_word(w, directed_rows[i].typed, typed_rsp);
      end

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 36 : (phase == 1) ? 55 : 0;
         repeat (RANDOM_WORDS / 3) begin
            n = sorted_model.size();
            if (n == 0) fill_mode = 1'b1;
            else if (n >= CAPACITY && $urandom_range(0, 2) == 0) fill_mode = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 5) w.opcode = OP_DUMP;
            else if (roll < 10) w.opcode = OP_DUMP_ALT;
            else if (roll < (fill_mode ? 70 : 35)) w.opcode = sli_pkg::OP_INSERT;
            else w.opcode = sli_pkg::OP_DELETE;
            // deletes mostly hit a stored value
            if (w.opcode == sli_pkg::OP_DELETE && n > 0 && $urandom_range(0, 3) != 0)
               w.value = sorted_model[$urandom_range(0, n - 1)];
            else
               w.value = pick_value();
            send_word(w, 1'b0, '0);
         end
      end
      start <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words sent, %0d result words checked, %0d mismatches",
               words_sent, rsp_count, error_count);
      $display("dumps %0d (empty %0d), inserts dropped on full %0d, deletes missed %0d",
               dump_count, empty_count, full_count, miss_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
